/* design/ffba_pkg.sv */
// Package for the first-fit block allocator: payload structs, codes and
// defaults shared by the cell chain and the top level. No dependencies.
package ffba_pkg;

   localparam int REQ_W            = 24;
   localparam int OUT_W            = 24;
   localparam int RATE_W           = 16;
   localparam int POOL_W           = 24;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 24;
   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int ADDR_BITS_DEF    = 24;
   localparam int HEADER_BYTES_DEF = 32;
   localparam int RATE_RESET       = 16;
   localparam int POOL_RESET       = 1048576;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_MERGE = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOFIT   = 2'd1,
      STATUS_NOMATCH = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLLECT_RATE = 2'd0,
      CSR_POOL_SIZE    = 2'd1,
      CSR_SPARE2       = 2'd2,
      CSR_SPARE3       = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_ALLOC = 2'd1,
      MODE_FREE  = 2'd2,
      MODE_MERGE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      FSM_IDLE  = 2'd0,
      FSM_MERGE = 2'd1,
      FSM_SCAN  = 2'd2,
      FSM_DONE  = 2'd3
   } fsm_type;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [REQ_W-1:0] request_size;
      logic [REQ_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] payload_address;
      logic [1:0]       status;
   } rsp_type;

   // Token that walks the cell chain, carrying the outcome of the pass.
   typedef struct packed {
      logic             tok;
      logic             done;
      status_type       status;
      logic [OUT_W-1:0] addr;
   } pkt_type;

   // Broadcast from the top level to every cell.
   typedef struct packed {
      mode_type         mode;
      logic             launch;
      logic             load;
      logic             full;
      logic [REQ_W-1:0] size;
      logic [REQ_W-1:0] faddr;
   } cmd_type;

endpackage

/* design/ffba_cell.sv */
// One table entry of the allocator chain with its share of the walking token.
// Depends on ffba_pkg.
module ffba_cell
   import ffba_pkg::*;
#(
   parameter int K            = 0,
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
   parameter int ADDR_BITS    = ADDR_BITS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int CNT_W        = $clog2(MAX_BLOCKS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   input  logic [CNT_W-1:0]     count,
   input  logic [ADDR_BITS-1:0] load_length,
   input  logic [ADDR_BITS-1:0] prev_start,
   input  logic [ADDR_BITS-1:0] prev_length,
   input  logic                 prev_used,
   input  logic                 prev_split,
   input  logic [ADDR_BITS-1:0] prev_spawn_start,
   input  logic [ADDR_BITS-1:0] prev_spawn_length,
   input  pkt_type              pkt_in,
   input  logic [ADDR_BITS-1:0] next_start,
   input  logic [ADDR_BITS-1:0] next_length,
   input  logic                 next_used,
   input  logic                 split_any,
   input  logic                 any_join,
   output logic [ADDR_BITS-1:0] start,
   output logic [ADDR_BITS-1:0] length,
   output logic                 used,
   output logic                 split,
   output logic                 joined,
   output logic [ADDR_BITS-1:0] spawn_start,
   output logic [ADDR_BITS-1:0] spawn_length,
   output pkt_type              pkt_out,
   output logic                 tok
);

   localparam int CMP_W = (ADDR_BITS > REQ_W) ? ADDR_BITS : REQ_W;
   localparam int SUM_W = CMP_W + 2;
   localparam logic [SUM_W-1:0] HDR = SUM_W'(HEADER_BYTES);
   localparam logic [ADDR_BITS-1:0] RESET_LEN =
      (K == 0) ? ADDR_BITS'(POOL_RESET - HEADER_BYTES) : '0;

   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [ADDR_BITS-1:0] length_ff, length_in;
   logic                 used_ff, used_in;
   logic                 visited_ff, visited_in;
   pkt_type              pkt_ff, pkt_in_next;

   logic             in_table, has_next, after, active;
   logic [SUM_W-1:0] len_ext, size_ext, leftover, payload_sum, spawn_sum, merge_sum;
   logic             fits, exact, fit_hit, match_hit;

   always_comb begin
      in_table    = CNT_W'(K) < count;
      has_next    = CNT_W'(K + 1) < count;
      after       = !visited_ff && !pkt_ff.tok;
      active      = pkt_ff.tok && !pkt_ff.done;
      len_ext     = SUM_W'(length_ff);
      size_ext    = SUM_W'(cmd.size);
      leftover    = len_ext - size_ext;
      fits        = len_ext >= size_ext;
      exact       = leftover < HDR;
      payload_sum = SUM_W'(SUM_W'(start_ff) + HDR);
      payload_sum = SUM_W'(payload_sum[ADDR_BITS-1:0]);
      spawn_sum   = SUM_W'(start_ff) + HDR + size_ext;
      merge_sum   = len_ext + HDR + SUM_W'(next_length);
      fit_hit     = (cmd.mode == MODE_ALLOC) && active && in_table && !used_ff && fits;
      match_hit   = (cmd.mode == MODE_FREE) && active && in_table &&
                    (payload_sum == SUM_W'(cmd.faddr));
      split       = fit_hit && !exact && !cmd.full;
      joined      = (cmd.mode == MODE_MERGE) && pkt_ff.tok && has_next &&
                    !used_ff && !next_used;
   end

   assign spawn_start  = spawn_sum[ADDR_BITS-1:0];
   assign spawn_length = ADDR_BITS'(leftover - HDR);

   always_comb begin
      pkt_out     = pkt_ff;
      pkt_out.tok = pkt_ff.tok && !joined;
      if (fit_hit) begin
         pkt_out.done = 1'b1;
         if (!exact && cmd.full) begin
            pkt_out.status = STATUS_FULL;
            pkt_out.addr   = '0;
         end else begin
            pkt_out.status = STATUS_OK;
            pkt_out.addr   = payload_sum[OUT_W-1:0];
         end
      end else if (match_hit) begin
         pkt_out.done   = 1'b1;
         pkt_out.status = STATUS_OK;
         pkt_out.addr   = '0;
      end
   end

   always_comb begin
      start_in    = start_ff;
      length_in   = length_ff;
      used_in     = used_ff;
      pkt_in_next = joined ? pkt_ff : pkt_in;
      visited_in  = cmd.launch ? 1'b0 : (visited_ff || pkt_ff.tok);
      if (cmd.load) begin
         start_in    = '0;
         length_in   = (K == 0) ? load_length : '0;
         used_in     = 1'b0;
         pkt_in_next = '0;
         visited_in  = 1'b0;
      end else if (fit_hit) begin
         if (exact) begin
            used_in = 1'b1;
         end else if (!cmd.full) begin
            length_in = size_ext[ADDR_BITS-1:0];
            used_in   = 1'b1;
         end
      end else if (match_hit) begin
         used_in = 1'b0;
      end else if (joined) begin
         length_in = merge_sum[ADDR_BITS-1:0];
      end else if (prev_split) begin
         start_in  = prev_spawn_start;
         length_in = prev_spawn_length;
         used_in   = 1'b0;
      end else if (split_any && after && (CNT_W'(K) <= count)) begin
         start_in  = prev_start;
         length_in = prev_length;
         used_in   = prev_used;
      end else if (any_join && after) begin
         start_in  = next_start;
         length_in = next_length;
         used_in   = next_used;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         length_ff  <= RESET_LEN;
         used_ff    <= 1'b0;
         visited_ff <= 1'b0;
         pkt_ff     <= '0;
      end else begin
         start_ff   <= start_in;
         length_ff  <= length_in;
         used_ff    <= used_in;
         visited_ff <= visited_in;
         pkt_ff     <= pkt_in_next;
      end
   end

   assign start  = start_ff;
   assign length = length_ff;
   assign used   = used_ff;
   assign tok    = pkt_ff.tok;

endmodule

/* design/first_fit_block_allocator_top.sv */
// Top level of the first-fit block allocator: control, registers and the
// chain of table cells. Depends on ffba_pkg and ffba_cell.

// The block table lives in a chain of MAX_BLOCKS cells, one entry per cell,
// kept in address order. Every allocate, free or merge launches a token at
// cell 0 that moves one cell per clock, but stays in a cell while that cell
// joins its entry with the next; the cell holding the token does the work of
// its entry, and when an allocate splits a block or a merge joins two, every
// cell the token has not yet reached shifts its entry one place in the same
// cycle. A free that triggers the collect_rate merge costs one merge pass
// plus one search pass. Opcode three launches no token and goes straight to
// the done state. A new request is taken once the previous result is placed
// in the output register, so it can be transferred while that result still
// waits on rsp_stall. Configuration writes are taken in any cycle; writing
// pool_size rebuilds the table as one free block at once.
module first_fit_block_allocator_top
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
   parameter int ADDR_BITS    = ADDR_BITS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   fsm_type              state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [RATE_W-1:0]    frees_ff, frees_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   opcode_type           op_ff, op_in;
   logic [REQ_W-1:0]     size_ff, size_in;
   logic [REQ_W-1:0]     faddr_ff, faddr_in;
   logic                 launch_ff, launch_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   rsp_type              result_ff, result_in;

   logic                 req_xfer, rsp_xfer, csr_xfer, load, exit_tok;
   logic [RATE_W-1:0]    frees_inc;
   logic [ADDR_BITS-1:0] load_length;
   cmd_type              cmd;
   pkt_type              exit_pkt;
   logic                 split_any, any_join;

   logic [ADDR_BITS-1:0] c_start [MAX_BLOCKS];
   logic [ADDR_BITS-1:0] c_length [MAX_BLOCKS];
   logic                 c_used [MAX_BLOCKS];
   logic [ADDR_BITS-1:0] c_spawn_start [MAX_BLOCKS];
   logic [ADDR_BITS-1:0] c_spawn_length [MAX_BLOCKS];
   pkt_type              c_pkt [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0] c_split, c_join, c_tok;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign load      = csr_xfer && (csr_index == CSR_POOL_SIZE);
   assign frees_inc = frees_ff + RATE_W'(1);

   // A pool smaller than one header leaves a zero-length first block.
   assign load_length = (csr_data[POOL_W-1:0] >= POOL_W'(HEADER_BYTES)) ?
                        ADDR_BITS'(csr_data[POOL_W-1:0] - POOL_W'(HEADER_BYTES)) : '0;

   assign split_any = |c_split;
   assign any_join  = |c_join;
   assign exit_pkt  = c_pkt[MAX_BLOCKS-1];
   assign exit_tok  = exit_pkt.tok;

   // The whole chain sees the same command in a cycle.
   always_comb begin
      cmd.launch = launch_ff;
      cmd.load   = load;
      cmd.full   = count_ff >= CNT_W'(MAX_BLOCKS);
      cmd.size   = size_ff;
      cmd.faddr  = faddr_ff;
      cmd.mode   = MODE_IDLE;
      if (state_ff == FSM_MERGE) begin
         cmd.mode = MODE_MERGE;
      end else if (state_ff == FSM_SCAN) begin
         cmd.mode = (op_ff == OP_ALLOC) ? MODE_ALLOC : MODE_FREE;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in  = state_ff;
      launch_in = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            if (req_xfer) begin
               case (opcode_type'(req_data.opcode))
                  OP_ALLOC: begin
                     state_in  = FSM_SCAN;
                     launch_in = 1'b1;
                  end
                  OP_FREE: begin
                     state_in  = (frees_inc >= rate_ff) ? FSM_MERGE : FSM_SCAN;
                     launch_in = 1'b1;
                  end
                  OP_MERGE: begin
                     state_in  = FSM_MERGE;
                     launch_in = 1'b1;
                  end
                  default: begin
                     state_in = FSM_DONE;
                  end
               endcase
            end
         end
         FSM_MERGE: begin
            if (exit_tok) begin
               if (op_ff == OP_FREE) begin
                  state_in  = FSM_SCAN;
                  launch_in = 1'b1;
               end else begin
                  state_in = FSM_DONE;
               end
            end
         end
         FSM_SCAN: begin
            if (exit_tok) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (!rsp_valid_ff || rsp_xfer) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Output and datapath control.
   always_comb begin
      req_stall    = (state_ff != FSM_IDLE);
      op_in        = op_ff;
      size_in      = size_ff;
      faddr_in     = faddr_ff;
      frees_in     = frees_ff;
      rate_in      = rate_ff;
      count_in     = count_ff;
      result_in    = result_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;

      if (req_xfer) begin
         op_in     = opcode_type'(req_data.opcode);
         size_in   = req_data.request_size;
         faddr_in  = req_data.free_address;
         result_in = '{payload_address: '0, status: STATUS_OK};
         if (opcode_type'(req_data.opcode) == OP_FREE) begin
            frees_in = (frees_inc >= rate_ff) ? '0 : frees_inc;
         end
      end

      if (state_ff == FSM_SCAN && exit_tok) begin
         if (exit_pkt.done) begin
            result_in = '{payload_address: exit_pkt.addr, status: exit_pkt.status};
         end else begin
            result_in.payload_address = '0;
            result_in.status = (op_ff == OP_ALLOC) ? STATUS_NOFIT : STATUS_NOMATCH;
         end
      end

      if (state_ff == FSM_DONE && (!rsp_valid_ff || rsp_xfer)) begin
         rsp_in       = result_ff;
         rsp_valid_in = 1'b1;
      end

      if (load) begin
         count_in = CNT_W'(1);
      end else if (split_any) begin
         count_in = count_ff + CNT_W'(1);
      end else if (any_join) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (csr_xfer && csr_index == CSR_COLLECT_RATE) begin
         rate_in = csr_data[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= CNT_W'(1);
         frees_ff     <= '0;
         rate_ff      <= RATE_W'(RATE_RESET);
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         frees_ff     <= frees_in;
         rate_ff      <= rate_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      size_ff   <= size_in;
      faddr_ff  <= faddr_in;
      result_ff <= result_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The chain. Cell 0 takes the fresh token; the last cell hands it back.
   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      logic [ADDR_BITS-1:0] p_start, p_length, p_spawn_start, p_spawn_length;
      logic [ADDR_BITS-1:0] n_start, n_length;
      logic                 p_used, p_split, n_used;
      pkt_type              p_pkt;

      if (k == 0) begin : g_head
         assign p_start        = '0;
         assign p_length       = '0;
         assign p_used         = 1'b0;
         assign p_split        = 1'b0;
         assign p_spawn_start  = '0;
         assign p_spawn_length = '0;
         assign p_pkt          = '{tok: launch_ff, done: 1'b0,
                                   status: STATUS_OK, addr: '0};
      end else begin : g_body
         assign p_start        = c_start[k-1];
         assign p_length       = c_length[k-1];
         assign p_used         = c_used[k-1];
         assign p_split        = c_split[k-1];
         assign p_spawn_start  = c_spawn_start[k-1];
         assign p_spawn_length = c_spawn_length[k-1];
         assign p_pkt          = c_pkt[k-1];
      end

      if (k == MAX_BLOCKS - 1) begin : g_tail
         assign n_start  = '0;
         assign n_length = '0;
         assign n_used   = 1'b0;
      end else begin : g_inner
         assign n_start  = c_start[k+1];
         assign n_length = c_length[k+1];
         assign n_used   = c_used[k+1];
      end

      ffba_cell #(
         .K            (k),
         .MAX_BLOCKS   (MAX_BLOCKS),
         .ADDR_BITS    (ADDR_BITS),
         .HEADER_BYTES (HEADER_BYTES),
         .CNT_W        (CNT_W)
      ) u_cell (
         .clock             (clock),
         .reset             (reset),
         .cmd               (cmd),
         .count             (count_ff),
         .load_length       (load_length),
         .prev_start        (p_start),
         .prev_length       (p_length),
         .prev_used         (p_used),
         .prev_split        (p_split),
         .prev_spawn_start  (p_spawn_start),
         .prev_spawn_length (p_spawn_length),
         .pkt_in            (p_pkt),
         .next_start        (n_start),
         .next_length       (n_length),
         .next_used         (n_used),
         .split_any         (split_any),
         .any_join          (any_join),
         .start             (c_start[k]),
         .length            (c_length[k]),
         .used              (c_used[k]),
         .split             (c_split[k]),
         .joined            (c_join[k]),
         .spawn_start       (c_spawn_start[k]),
         .spawn_length      (c_spawn_length[k]),
         .pkt_out           (c_pkt[k]),
         .tok               (c_tok[k])
      );
   end

   // At most one token is ever in flight along the chain.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(c_tok))
      else $error("more than one token in the cell chain");

   // A split and a join never happen in the same cycle.
   a_no_split_join: assert property (@(posedge clock) disable iff (reset)
      !(split_any && any_join))
      else $error("split and join in the same cycle");

   // The table never grows past its capacity.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("block count beyond capacity");

   // A new result appears only when leaving the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FSM_DONE))
      else $error("result raised outside the done state");

endmodule

/* tb/sv/first_fit_block_allocator_top_test.sv */
// Testbench for the first-fit block allocator: a directed and random request
// stream checked against an allocation table predictor. Depends on ffba_pkg and the top level.
`timescale 1ns / 1ps

module first_fit_block_allocator_top_test;
   import ffba_pkg::*;

   localparam int HDR      = HEADER_BYTES_DEF;
   localparam int NBLK     = MAX_BLOCKS_DEF;
   localparam int WDOG_MAX = 5000;
   localparam int SETTLE   = 300;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   first_fit_block_allocator_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Shadow copy of the allocation table and its registers.
   logic [23:0] tbl_start [NBLK];
   logic [23:0] tbl_len   [NBLK];
   bit          tbl_used  [NBLK];
   int          tbl_count;
   logic [15:0] free_count;
   logic [15:0] merge_rate;
   logic [23:0] pool_bytes;

   logic [23:0] live_addrs [$];   // payload addresses currently handed out
   req_type     pending_reqs [$];
   rsp_type     expected_rsps [$];
   int          mismatches;
   bit          quiet_mode;       // no idling on either side while set
   int          wdog;

   function automatic int draw_wait();
      return quiet_mode ? 0 : $urandom_range(0, 9);
   endfunction

   function automatic void rebuild_pool();
      for (int k = 0; k < NBLK; k++) begin
         tbl_start[k] = '0;
         tbl_len[k]   = '0;
         tbl_used[k]  = 1'b0;
      end
      tbl_len[0] = (pool_bytes >= HDR) ? pool_bytes - HDR : '0;
      tbl_count  = 1;
      live_addrs.delete();
   endfunction

   function automatic void coalesce();
      int i;
      i = 0;
      while (i + 1 < tbl_count) begin
         if (!tbl_used[i] && !tbl_used[i+1]) begin
            tbl_len[i] = tbl_len[i] + HDR + tbl_len[i+1];
            for (int k = i + 1; k + 1 < tbl_count; k++) begin
               tbl_start[k] = tbl_start[k+1];
               tbl_len[k]   = tbl_len[k+1];
               tbl_used[k]  = tbl_used[k+1];
            end
            tbl_count--;
            tbl_start[tbl_count] = '0;
            tbl_len[tbl_count]   = '0;
            tbl_used[tbl_count]  = 1'b0;
         end else begin
            i++;
         end
      end
   endfunction

   function automatic rsp_type first_fit(logic [23:0] size);
      rsp_type r;
      logic [23:0] left;
      r = '0;
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_used[i] || tbl_len[i] < size) continue;
         left = tbl_len[i] - size;
         if (left >= HDR) begin
            if (tbl_count >= NBLK) begin
               r.status = STATUS_FULL;
               return r;
            end
            for (int k = tbl_count; k > i + 1; k--) begin
               tbl_start[k] = tbl_start[k-1];
               tbl_len[k]   = tbl_len[k-1];
               tbl_used[k]  = tbl_used[k-1];
            end
            tbl_start[i+1] = tbl_start[i] + HDR + size;
            tbl_len[i+1]   = left - HDR;
            tbl_used[i+1]  = 1'b0;
            tbl_len[i]     = size;
            tbl_count++;
         end
         // A near fit keeps its whole length; only the used flag changes.
         tbl_used[i]       = 1'b1;
         r.payload_address = tbl_start[i] + HDR;
         r.status          = STATUS_OK;
         live_addrs.push_back(r.payload_address);
         return r;
      end
      r.status = STATUS_NOFIT;
      return r;
   endfunction

   function automatic rsp_type release_block(logic [23:0] addr);
      rsp_type r;
      logic [23:0] pay;
      r = '0;
      // The free counter advances before the address is looked up.
      free_count = free_count + 1;
      if (free_count >= merge_rate) begin
         coalesce();
         free_count = '0;
      end
      for (int i = 0; i < tbl_count; i++) begin
         pay = tbl_start[i] + HDR;
         if (pay == addr) begin
            tbl_used[i] = 1'b0;
            foreach (live_addrs[j])
               if (live_addrs[j] == addr) begin
                  live_addrs.delete(j);
                  break;
               end
            r.status = STATUS_OK;
            return r;
         end
      end
      r.status = STATUS_NOMATCH;
      return r;
   endfunction

   function automatic rsp_type predict_rsp(req_type q);
      rsp_type r;
      r = '0;
      case (opcode_type'(q.opcode))
         OP_ALLOC: r = first_fit(q.request_size);
         OP_FREE:  r = release_block(q.free_address);
         OP_MERGE: coalesce();
         default:  r = '0;
      endcase
      return r;
   endfunction

   // Request driver: one transfer per queued item, with a random gap after it.
   int req_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         req_gap   = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsps.push_back(predict_rsp(req_data));
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap--;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
               req_gap   = draw_wait();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each transfer with the oldest expected result, then
   // stalls the next result while a randomly drawn hold count runs down.
   int rsp_hold;
   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual addr %h status %0d",
                        $realtime, rsp_data.payload_address, rsp_data.status);
               mismatches++;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (exp_r.payload_address !== rsp_data.payload_address) begin
                  $display("%0t: payload_address expected %h actual %h", $realtime,
                           exp_r.payload_address, rsp_data.payload_address);
                  mismatches++;
               end
               if (exp_r.status !== rsp_data.status) begin
                  $display("%0t: status expected %0d actual %0d", $realtime,
                           exp_r.status, rsp_data.status);
                  mismatches++;
               end
            end
            rsp_hold = draw_wait();
         end else if (rsp_valid && rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // Watchdog: any transfer on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         wdog <= 0;
      end else if (wdog >= WDOG_MAX) begin
         $display("Mismatches found");
         $finish;
      end else begin
         wdog <= wdog + 1;
      end
   end

   // Register writes happen only while the allocator is idle, so the shadow
   // registers are updated right at the write.
   task automatic write_csr(csr_index_type idx, logic [23:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_COLLECT_RATE) begin
         merge_rate = val[15:0];
      end else if (idx == CSR_POOL_SIZE) begin
         pool_bytes = val;
         rebuild_pool();
      end
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send(opcode_type op, logic [23:0] size, logic [23:0] addr);
      req_type q;
      q.opcode       = op;
      q.request_size = size;
      q.free_address = addr;
      // Keep the queue short so frees can pick from current allocations.
      while (pending_reqs.size() > 0) @(posedge clock);
      pending_reqs.push_back(q);
   endtask

   task automatic random_item();
      int pick;
      logic [23:0] size;
      logic [23:0] addr;
      pick = $urandom_range(0, 99);
      size = $urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFFFFFF)
                                        : $urandom_range(0, 400);
      if (live_addrs.size() > 0 && $urandom_range(0, 4) != 0)
         addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
      else
         addr = $urandom_range(0, 24'hFFFFFF);
      if (pick < 48)      send(OP_ALLOC, size, $urandom_range(0, 24'hFFFFFF));
      else if (pick < 88) send(OP_FREE, $urandom_range(0, 24'hFFFFFF), addr);
      else if (pick < 96) send(OP_MERGE, $urandom, $urandom);
      else                send(OP_NOP, $urandom, $urandom);
   endtask

   task automatic random_phase(logic [15:0] rate, logic [23:0] pool, int n, bit calm);
      write_csr(CSR_COLLECT_RATE, rate);
      write_csr(CSR_POOL_SIZE, pool);
      quiet_mode = calm;
      repeat (n) random_item();
      wait_idle();
      quiet_mode = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      mismatches = 0;
      quiet_mode = 1'b0;
      merge_rate = RATE_RESET;
      pool_bytes = POOL_RESET;
      free_count = '0;
      rebuild_pool();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part on the reset pool: zero and oversized requests, frees of
      // unknown, valid and already free addresses, merge and the unused opcode.
      send(OP_ALLOC, 24'd0, 24'hFFFFFF);
      send(OP_ALLOC, 24'd1, 24'd0);
      send(OP_ALLOC, 24'hFFFFFF, 24'd0);
      send(OP_ALLOC, 24'd100, 24'd0);
      send(OP_FREE, 24'd0, 24'd0);
      send(OP_FREE, 24'hFFFFFF, 24'hFFFFFF);
      send(OP_FREE, 24'd0, 24'd32);
      send(OP_FREE, 24'd0, 24'd32);
      send(OP_MERGE, 24'hFFFFFF, 24'hFFFFFF);
      send(OP_NOP, 24'hFFFFFF, 24'hFFFFFF);
      send(OP_ALLOC, 24'd1048576 - 24'd64 - 24'd20, 24'd0);
      wait_idle();

      // Pool of two headers: a one-byte request takes the whole block.
      write_csr(CSR_POOL_SIZE, 24'd64);
      send(OP_ALLOC, 24'd1, 24'd0);
      send(OP_ALLOC, 24'd1, 24'd0);
      send(OP_FREE, 24'd0, 24'd32);
      // Pool smaller than a header leaves a zero-length block.
      wait_idle();
      write_csr(CSR_POOL_SIZE, 24'd10);
      send(OP_ALLOC, 24'd0, 24'd0);
      send(OP_ALLOC, 24'd1, 24'd0);
      wait_idle();

      // Fill the table on the largest pool until a split reports it full.
      write_csr(CSR_COLLECT_RATE, 16'hFFFF);
      write_csr(CSR_POOL_SIZE, 24'hFFFFFF);
      quiet_mode = 1'b1;
      repeat (NBLK + 4) send(OP_ALLOC, $urandom_range(1, 60), 24'd0);
      send(OP_ALLOC, 24'hFFFFFF, 24'd0);
      quiet_mode = 1'b0;
      wait_idle();

      // Random phases over a spread of register settings.
      random_phase(16'd16, 24'd4096, 180, 1'b0);
      random_phase(16'd1, 24'd64, 100, 1'b0);
      random_phase(16'd0, 24'hFFFFFF, 180, 1'b1);
      random_phase(16'hFFFF, 24'd2000, 150, 1'b0);
      random_phase(16'd5, 24'd1048576, 180, 1'b0);

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/ffba_pkg.sv
design/ffba_cell.sv
design/first_fit_block_allocator_top.sv
tb/sv/first_fit_block_allocator_top_test.sv
